@@ rtl/cads_pkg.sv @@
// ----------------------------------------------------------------------------
// cads_pkg
// Shared types and constants for the chopper ADC sequencer and duty calculator
// ----------------------------------------------------------------------------
package cads_pkg;

  // fixed field widths
  localparam int unsigned ConvW      = 10;
  localparam int unsigned PowerW     = 20;
  localparam int unsigned EffW       = 16;
  localparam int unsigned DutyW      = 16;
  localparam int unsigned PwmTopW    = 16;
  localparam int unsigned PowerCmdW  = 16;

  // defaults and constants
  localparam int unsigned AdcBitsDef  = 10;
  localparam logic [PwmTopW-1:0] PwmTopReset = 16'd159;
  localparam int unsigned EffFracBits = 12;
  localparam int unsigned DutyShift   = 15;
  localparam int unsigned ChanCnt     = 4;
  localparam int unsigned ChanW       = $clog2(ChanCnt);

  // channel order of the round robin
  localparam logic [ChanW-1:0] ChanVin  = 2'd0;
  localparam logic [ChanW-1:0] ChanIin  = 2'd1;
  localparam logic [ChanW-1:0] ChanVout = 2'd2;
  localparam logic [ChanW-1:0] ChanIout = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } cads_state_e;

  // divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } cads_div_stat_t;

endpackage

@@ rtl/cads_div.sv @@
// ----------------------------------------------------------------------------
// cads_div
// Bit-serial efficiency divider: (num << 12) / den, saturating, zero on den 0
// ----------------------------------------------------------------------------
module cads_div import cads_pkg::*; #(
  parameter int unsigned PW = PowerW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [PW-1:0]     num_i,
  input  logic [PW-1:0]     den_i,
  output cads_div_stat_t    stat_o,
  output logic [EffW-1:0]   quot_o
);

  localparam int unsigned SatShift = EffW - EffFracBits;
  localparam int unsigned CntW     = $clog2(EffW);

  logic              busy_q;
  logic              done_q;
  logic [CntW-1:0]   cnt_q;
  logic [PW-1:0]     rem_q;
  logic [EffW-1:0]   low_q;
  logic [EffW-1:0]   quot_q;

  logic [PW:0]       rem_sh;
  logic              ge;
  logic [PW:0]       diff;
  logic              sat;

  // quotient above 16 bits exactly when num >= den * 16
  assign sat    = {{SatShift{1'b0}}, num_i} >= {den_i, {SatShift{1'b0}}};
  assign rem_sh = {rem_q, low_q[EffW-1]};
  assign ge     = rem_sh >= {1'b0, den_i};
  assign diff   = rem_sh - {1'b0, den_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      cnt_q <= '0;
      if (den_i == '0 || sat) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
      end
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntW'(EffW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= PW'(num_i >> SatShift);
      low_q <= {num_i[SatShift-1:0], {EffFracBits{1'b0}}};
      if (den_i == '0) begin
        quot_q <= '0;
      end else if (sat) begin
        quot_q <= '1;
      end else begin
        quot_q <= '0;
      end
    end else if (busy_q) begin
      rem_q  <= ge ? diff[PW-1:0] : rem_sh[PW-1:0];
      low_q  <= {low_q[EffW-2:0], 1'b0};
      quot_q <= {quot_q[EffW-2:0], ge};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;

endmodule

@@ rtl/chopper_adc_sequencer_duty_calc.sv @@
// ----------------------------------------------------------------------------
// chopper_adc_sequencer_duty_calc
// ADC channel sequencer with serial power, efficiency and PWM duty arithmetic
// ----------------------------------------------------------------------------
// channel   handshake                 payload
// in        in_valid_i / in_ready_o   tick, eoc level, code, commands, power ref
// out       out_valid_o / out_ready_i clock, run flag, codes, powers, eff, duty
// cfg       cfg_we_i                  cfg_wdata_i = pwm_top
//
// a beat without the run flag goes from accept through ST_OUT to the output
// register, and ST_OUT holds while the previous result still waits there
// with the run flag set: shift-add multiply (both powers and the duty product
// side by side, the powers in the first CodeW steps), the load state, then a
// 16-step divider; zero input power or a saturated efficiency skips the
// divide steps
// reset clears the sequencer, channel index, flags and held results
// a beat is taken while the previous result still waits in the output register;
// the next result then stalls until that one is taken
// ----------------------------------------------------------------------------
module chopper_adc_sequencer_duty_calc import cads_pkg::*; #(
  parameter int unsigned ADC_BITS = AdcBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [PwmTopW-1:0]    cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  adc_half_tick_i,
  input  logic                  eoc_level_i,
  input  logic [ConvW-1:0]      conv_value_i,
  input  logic                  enable_cmd_i,
  input  logic                  regen_cmd_i,
  input  logic                  reverse_cmd_i,
  input  logic [PowerCmdW-1:0]  power_cmd_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  adc_clock_level_o,
  output logic                  run_flag_o,
  output logic [ConvW-1:0]      in_voltage_code_o,
  output logic [ConvW-1:0]      in_current_code_o,
  output logic [ConvW-1:0]      out_voltage_code_o,
  output logic [ConvW-1:0]      out_current_code_o,
  output logic [PowerW-1:0]     in_power_o,
  output logic [PowerW-1:0]     out_power_o,
  output logic [EffW-1:0]       efficiency_o,
  output logic [DutyW-1:0]      duty_forward_o,
  output logic [DutyW-1:0]      duty_reverse_o
);

  localparam int unsigned CodeW    = (ADC_BITS < ConvW) ? ADC_BITS : ConvW;
  localparam int unsigned PW       = 2 * CodeW;
  localparam int unsigned MulSteps = PwmTopW;
  localparam int unsigned MulCntW  = $clog2(MulSteps);
  localparam int unsigned NumW     = PowerCmdW + 2;
  localparam int unsigned DProdW   = 2 * PwmTopW;
  localparam logic signed [NumW-1:0] PowerOne = NumW'(1 << (PowerCmdW - 2));

  cads_state_e state_q, state_d;

  logic [PwmTopW-1:0]  pwm_top_q;
  logic                eoc_prev_q;
  logic [ChanW-1:0]    chan_idx_q, chan_idx_d;
  logic                adc_clk_q;
  logic                run_q, run_d;
  logic [CodeW-1:0]    vin_q, iin_q, vout_q, iout_q;
  logic [CodeW-1:0]    vin_d, iin_d, vout_d, iout_d;
  logic [PW-1:0]       pin_hold_q, pout_hold_q;
  logic [EffW-1:0]     eff_hold_q;
  logic [DutyW-1:0]    duty_fwd_q, duty_rev_q;
  logic                en_q, rev_q;

  // shift-add product registers: upper half accumulates, multiplier drains out
  logic [PW:0]         pp_in_q, pp_out_q;
  logic [DProdW:0]     pp_duty_q;
  logic [MulCntW-1:0]  mul_cnt_q;

  logic                in_acc;
  logic                eoc_rise;
  logic [CodeW-1:0]    code;
  logic signed [NumW-1:0] num;
  logic [PwmTopW-1:0]  num_mag;
  logic                pwr_step;
  logic [CodeW:0]      sum_in, sum_out;
  logic [PwmTopW:0]    sum_duty;
  logic [DutyW-1:0]    duty_raw;

  logic                mul_last;
  logic                div_start;
  logic                out_load;
  cads_div_stat_t      div_stat;
  logic [EffW-1:0]     div_quot;

  logic                out_valid_q;
  logic                o_clk_q, o_run_q;
  logic [ConvW-1:0]    o_vin_q, o_iin_q, o_vout_q, o_iout_q;
  logic [PowerW-1:0]   o_pin_q, o_pout_q;
  logic [EffW-1:0]     o_eff_q;
  logic [DutyW-1:0]    o_fwd_q, o_rev_q;

  assign in_acc   = in_valid_i && in_ready_o;
  assign eoc_rise = eoc_level_i && !eoc_prev_q;
  assign code     = conv_value_i[CodeW-1:0];

  // channel latch and run flag for the incoming beat
  always_comb begin
    vin_d      = vin_q;
    iin_d      = iin_q;
    vout_d     = vout_q;
    iout_d     = iout_q;
    chan_idx_d = chan_idx_q;
    run_d      = adc_half_tick_i ? 1'b0 : run_q;
    if (eoc_rise) begin
      chan_idx_d = chan_idx_q + 1'b1;
      case (chan_idx_q)
        ChanVin:  vin_d = code;
        ChanIin:  iin_d = code;
        ChanVout: vout_d = code;
        ChanIout: begin
          iout_d = code;
          run_d  = 1'b1;
        end
        default: vin_d = vin_q;
      endcase
    end
  end

  // duty numerator, clamped at zero; its positive range fits 16 bits
  assign num = NumW'($signed(power_cmd_i)) + PowerOne - (regen_cmd_i ? PowerOne : '0);
  assign num_mag = (num > 0) ? num[PwmTopW-1:0] : '0;

  assign pwr_step = mul_cnt_q < MulCntW'(CodeW);
  assign sum_in   = {1'b0, pp_in_q[PW-1:CodeW]} + {1'b0, vin_q};
  assign sum_out  = {1'b0, pp_out_q[PW-1:CodeW]} + {1'b0, vout_q};
  assign sum_duty = {1'b0, pp_duty_q[DProdW-1:PwmTopW]} + {1'b0, pwm_top_q};
  assign mul_last = mul_cnt_q == MulCntW'(MulSteps - 1);

  assign duty_raw = pp_duty_q[DProdW-1] ? '1 : pp_duty_q[DProdW-2:DutyShift];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = run_d ? ST_MUL : ST_OUT;
      ST_MUL:  if (mul_last) state_d = ST_LOAD;
      ST_LOAD: state_d = ST_DIV;
      ST_DIV:  if (div_stat.done) state_d = ST_OUT;
      ST_OUT:  if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_LOAD: div_start = 1'b1;
      ST_OUT:  out_load = !out_valid_q || out_ready_i;
      default: in_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pwm_top_q   <= PwmTopReset;
      eoc_prev_q  <= 1'b0;
      chan_idx_q  <= '0;
      adc_clk_q   <= 1'b0;
      run_q       <= 1'b0;
      vin_q       <= '0;
      iin_q       <= '0;
      vout_q      <= '0;
      iout_q      <= '0;
      pin_hold_q  <= '0;
      pout_hold_q <= '0;
      eff_hold_q  <= '0;
      duty_fwd_q  <= '0;
      duty_rev_q  <= '0;
      mul_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) pwm_top_q <= cfg_wdata_i;
      if (in_acc) begin
        if (adc_half_tick_i) adc_clk_q <= ~adc_clk_q;
        eoc_prev_q <= eoc_level_i;
        chan_idx_q <= chan_idx_d;
        run_q      <= run_d;
        vin_q      <= vin_d;
        iin_q      <= iin_d;
        vout_q     <= vout_d;
        iout_q     <= iout_d;
        mul_cnt_q  <= '0;
      end else if (state_q == ST_MUL) begin
        mul_cnt_q <= mul_cnt_q + 1'b1;
      end
      if (state_q == ST_LOAD) begin
        pin_hold_q  <= pp_in_q[PW-1:0];
        pout_hold_q <= pp_out_q[PW-1:0];
        duty_fwd_q  <= (en_q && !rev_q) ? duty_raw : '0;
        duty_rev_q  <= (en_q && rev_q) ? duty_raw : '0;
      end
      if (state_q == ST_DIV && div_stat.done) eff_hold_q <= div_quot;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // serial multipliers and output payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      en_q      <= enable_cmd_i;
      rev_q     <= reverse_cmd_i;
      pp_in_q   <= {{(CodeW + 1){1'b0}}, iin_d};
      pp_out_q  <= {{(CodeW + 1){1'b0}}, iout_d};
      pp_duty_q <= {{(PwmTopW + 1){1'b0}}, num_mag};
    end else if (state_q == ST_MUL) begin
      if (pwr_step) begin
        pp_in_q  <= pp_in_q[0] ? {1'b0, sum_in, pp_in_q[CodeW-1:1]}
                               : {1'b0, pp_in_q[PW:1]};
        pp_out_q <= pp_out_q[0] ? {1'b0, sum_out, pp_out_q[CodeW-1:1]}
                                : {1'b0, pp_out_q[PW:1]};
      end
      pp_duty_q <= pp_duty_q[0] ? {1'b0, sum_duty, pp_duty_q[PwmTopW-1:1]}
                                : {1'b0, pp_duty_q[DProdW:1]};
    end
    if (out_load) begin
      o_clk_q  <= adc_clk_q;
      o_run_q  <= run_q;
      o_vin_q  <= ConvW'(vin_q);
      o_iin_q  <= ConvW'(iin_q);
      o_vout_q <= ConvW'(vout_q);
      o_iout_q <= ConvW'(iout_q);
      o_pin_q  <= PowerW'(pin_hold_q);
      o_pout_q <= PowerW'(pout_hold_q);
      o_eff_q  <= eff_hold_q;
      o_fwd_q  <= duty_fwd_q;
      o_rev_q  <= duty_rev_q;
    end
  end

  cads_div #(
    .PW (PW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (pp_out_q[PW-1:0]),
    .den_i   (pp_in_q[PW-1:0]),
    .stat_o  (div_stat),
    .quot_o  (div_quot)
  );

  assign out_valid_o        = out_valid_q;
  assign adc_clock_level_o  = o_clk_q;
  assign run_flag_o         = o_run_q;
  assign in_voltage_code_o  = o_vin_q;
  assign in_current_code_o  = o_iin_q;
  assign out_voltage_code_o = o_vout_q;
  assign out_current_code_o = o_iout_q;
  assign in_power_o         = o_pin_q;
  assign out_power_o        = o_pout_q;
  assign efficiency_o       = o_eff_q;
  assign duty_forward_o     = o_fwd_q;
  assign duty_reverse_o     = o_rev_q;

  // the run flag only comes up on the fourth channel, which wraps the index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(run_q) |-> chan_idx_q == ChanVin)
    else $error("run flag rose without a completed channel round");

  // divider only reports back while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide phase");

  // arithmetic runs only for beats that leave the run flag set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL |-> run_q)
    else $error("multiply phase without run flag");

  // a new beat is never taken while the divider is still busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> !in_ready_o)
    else $error("input ready while divider busy");

endmodule
